/* rtl/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg: shared types and codes
// Opcodes, status codes, sequencer states and the unit command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package cia_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_REV = 3'd5,
        OP_NA6 = 3'd6,
        OP_NA7 = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_REVD,
        S_REVA,
        S_FIN,
        S_OUT
    } t_state;

    // control from sequencer to the shift/add datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
        logic rev_div_step;
        logic rev_acc_step;
    } t_ctl;

    localparam int unsigned W = 64;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

endpackage
`default_nettype wire

/* rtl/cia_dpath.sv */
// ----------------------------------------------------------------------------
// cia_dpath: shared shift/subtract/add datapath
// Radix-2 multiply and divide steps on magnitudes plus decimal digit steps.
// ----------------------------------------------------------------------------
`default_nettype none
module cia_dpath (
    input  wire logic           i_clk,
    input  wire cia_pkg::t_ctl  i_ctl,
    input  wire logic [63:0]    i_a_mag,
    input  wire logic [63:0]    i_b_mag,
    output logic [127:0]        o_prod,
    output logic [63:0]         o_quot,
    output logic [63:0]         o_rem,
    output logic [63:0]         o_acc,
    output logic                o_acc_ovf,
    output logic                o_mag_zero
);
    import cia_pkg::*;

    logic [127:0] r_prod;
    logic [63:0]  r_mcand, r_mplier, r_quot, r_rem, r_dvsr;
    logic [63:0]  r_mag, r_digq, r_acc;
    logic [3:0]   r_dig;
    logic         r_ovf;
    logic [64:0]  w_trial;
    logic [63:0]  w_rem_sh;
    logic [67:0]  w_acc10;
    logic [19:0]  w_dchunk;
    logic [39:0]  w_dprod;
    logic [15:0]  w_dq;
    logic [19:0]  w_drem;

    // shared trial subtract: restoring divide step
    assign w_rem_sh = {r_rem[62:0], r_quot[63]};
    assign w_trial  = {r_rem[63], w_rem_sh} - {1'b0, r_dvsr};
    assign w_acc10  = {4'd0, r_acc} * 68'd10 + {64'd0, r_dig};

    // remainder plus next 16 bits, divided by 10 with a reciprocal multiply
    assign w_dchunk = {r_dig, r_mag[63:48]};
    assign w_dprod  = {20'd0, w_dchunk} * 40'd838861;
    assign w_dq     = w_dprod[38:23];
    assign w_drem   = w_dchunk - {4'd0, w_dq} * 20'd10;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod   <= '0;
            r_mcand  <= i_a_mag;
            r_mplier <= i_b_mag;
            r_quot   <= i_a_mag;
            r_rem    <= '0;
            r_dvsr   <= i_b_mag;
            r_mag    <= i_a_mag;
            r_digq   <= '0;
            r_acc    <= '0;
            r_dig    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_ctl.mul_step) begin
                if (r_mplier[63]) begin
                    r_prod <= {r_prod[126:0], 1'b0} + {64'd0, r_mcand};
                end else begin
                    r_prod <= {r_prod[126:0], 1'b0};
                end
                r_mplier <= {r_mplier[62:0], 1'b0};
            end
            if (i_ctl.div_step) begin
                if (!w_trial[64]) begin
                    r_rem  <= w_trial[63:0];
                    r_quot <= {r_quot[62:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_quot <= {r_quot[62:0], 1'b0};
                end
            end
            // divide magnitude by 10, 16 bits per cycle, 4 steps
            if (i_ctl.rev_div_step) begin
                r_dig  <= w_drem[3:0];
                r_digq <= {r_digq[47:0], w_dq};
                r_mag  <= {r_mag[47:0], 16'd0};
            end
            if (i_ctl.rev_acc_step) begin
                if (w_acc10 > {4'd0, MAX_POS}) begin
                    r_ovf <= 1'b1;
                end
                r_acc <= w_acc10[63:0];
                r_mag <= r_digq;
                r_dig <= '0;
            end
        end
    end

    assign o_prod     = r_prod;
    assign o_quot     = r_quot;
    assign o_rem      = r_rem;
    assign o_acc      = r_acc;
    assign o_acc_ovf  = r_ovf;
    assign o_mag_zero = (r_mag == '0);
endmodule
`default_nettype wire

/* rtl/checked_integer_alu.sv */
// ----------------------------------------------------------------------------
// checked_integer_alu: checked signed 64-bit ALU
// Add, subtract, multiply, divide, floored modulo, digit reversal with status.
// ----------------------------------------------------------------------------
// channel | signals                                   | dir
// in      | i_valid/o_ready, i_req_type, i_operand_a/b | in
// out     | o_valid/i_ready, o_result_value, o_status_code | out
// Add/subtract finish in S_FIN; multiply, divide and modulo load the datapath there,
// step in S_MUL or S_DIV, then S_REVA; reversal loops in S_REVD (4 digit steps, 1
// accumulate per decimal digit), then S_REVA. Multiply/divide use the one-bit-per-cycle
// shift/add/subtract datapath. After each output transfer S_IDLE takes the next input.
// Synchronous active-low reset empties the block. A stalled result holds
// in the output register; no new transfer is taken until it leaves.
`default_nettype none
module checked_integer_alu (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_req_type,
    input  wire logic signed [63:0] i_operand_a,
    input  wire logic signed [63:0] i_operand_b,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [63:0]      o_result_value,
    output logic [1:0]              o_status_code
);
    import cia_pkg::*;

    t_state r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    t_op         r_op;
    logic [63:0] r_a, r_b, r_res, n_res;
    t_status     r_st, n_st;
    t_ctl        w_ctl;
    logic [127:0] w_prod;
    logic [63:0] w_quot, w_rem, w_acc, w_amag, w_bmag, w_r;
    logic        w_ovf, w_mzero, w_an, w_bn;
    logic [64:0] w_sum;
    logic [127:0] w_sprod;

    assign w_an   = r_a[63];
    assign w_bn   = r_b[63];
    assign w_amag = w_an ? (64'd0 - r_a) : r_a;
    assign w_bmag = w_bn ? (64'd0 - r_b) : r_b;

    cia_dpath u_dpath (
        .i_clk(i_clk), .i_ctl(w_ctl),
        .i_a_mag(w_amag), .i_b_mag(w_bmag),
        .o_prod(w_prod), .o_quot(w_quot), .o_rem(w_rem),
        .o_acc(w_acc), .o_acc_ovf(w_ovf), .o_mag_zero(w_mzero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        if (o_ready && i_valid) begin
            r_op <= t_op'(i_req_type);
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
        r_res <= n_res;
        r_st  <= n_st;
    end

    assign w_sum   = {r_a[63], r_a} + (r_op == OP_SUB ? ~{r_b[63], r_b} + 65'd1
                                                      : {r_b[63], r_b});
    assign w_sprod = (w_an ^ w_bn) ? (128'd0 - w_prod) : w_prod;
    assign w_r     = w_rem;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_st    = r_st;
        w_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_FIN;
                    n_cnt   = '0;
                end
            end
            S_FIN: begin
                // first cycle after capture: load datapath or finish directly
                n_state = S_OUT;
                n_res = '0;
                n_st  = ST_OK;
                case (r_op)
                    OP_ADD, OP_SUB: begin
                        if (w_sum[64] != w_sum[63]) begin
                            n_st = w_sum[64] ? ST_UNDER : ST_OVER;
                        end else begin
                            n_res = w_sum[63:0];
                        end
                    end
                    OP_MUL: begin
                        w_ctl.load = 1'b1;
                        n_state = S_MUL;
                    end
                    OP_DIV, OP_MOD: begin
                        if (r_b == '0) begin
                            n_st = ST_DIVZ;
                        end else begin
                            w_ctl.load = 1'b1;
                            n_state = S_DIV;
                        end
                    end
                    OP_REV: begin
                        w_ctl.load = 1'b1;
                        n_state = S_REVD;
                    end
                    default: ;
                endcase
            end
            S_MUL: begin
                w_ctl.mul_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_state = S_REVA;
                    n_cnt = '0;
                end
            end
            S_DIV: begin
                w_ctl.div_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_state = S_REVA;
                    n_cnt = '0;
                end
            end
            S_REVD: begin
                if (r_cnt == 7'd0 && w_mzero) begin
                    n_state = S_REVA;
                end else if (r_cnt == 7'd4) begin
                    w_ctl.rev_acc_step = 1'b1;
                    n_cnt = '0;
                end else begin
                    w_ctl.rev_div_step = 1'b1;
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_REVA: begin
                // result assembly
                n_state = S_OUT;
                n_res = '0;
                n_st  = ST_OK;
                case (r_op)
                    OP_MUL: begin
                        if (w_sprod[127:63] != {65{w_sprod[127]}}) begin
                            n_st = (w_an ^ w_bn) ? ST_UNDER : ST_OVER;
                        end else begin
                            n_res = w_sprod[63:0];
                        end
                        if (r_a == '0 || r_b == '0) begin
                            n_st  = ST_OK;
                            n_res = '0;
                        end
                    end
                    OP_DIV: begin
                        if (!w_bn || !(w_an ^ w_bn)) begin
                            n_res = (w_an ^ w_bn) ? 64'd0 - w_quot : w_quot;
                        end else begin
                            n_res = 64'd0 - w_quot;
                        end
                        if (!(w_an ^ w_bn) && w_quot[63]) begin
                            n_st  = ST_OVER;
                            n_res = '0;
                        end
                    end
                    OP_MOD: begin
                        if (w_r == '0) begin
                            n_res = '0;
                        end else if (w_an == w_bn) begin
                            n_res = w_an ? 64'd0 - w_r : w_r;
                        end else begin
                            n_res = w_an ? r_b - w_r : w_r - w_bmag;
                        end
                    end
                    OP_REV: begin
                        if (w_ovf) begin
                            n_st = ST_OVER;
                        end else begin
                            n_res = w_an ? 64'd0 - w_acc : w_acc;
                        end
                    end
                    default: ;
                endcase
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_result_value = r_res;
    assign o_status_code  = r_st;

    a_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status_code != ST_OK) |-> o_result_value == '0)
        else $error("nonzero result with error status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value))
        else $error("result lost while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("accepting while holding result");
endmodule
`default_nettype wire

/* test/checked_integer_alu_tb.sv */
// ----------------------------------------------------------------------------
// checked_integer_alu_tb: self-checking regression for checked_integer_alu
// Directed table of operand extremes and error cases, then random requests
// biased to boundaries, checked against an in-bench predictor with random
// idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none
module checked_integer_alu_tb;
    import cia_pkg::*;

    localparam logic signed [63:0] SMAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;
    localparam int N_RANDOM = 1400;
    localparam int LIMIT = 6000000;

    typedef struct {
        t_op op;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic check;
        logic signed [63:0] res;
        t_status st;
    } t_row;

    typedef struct {
        logic signed [63:0] res;
        t_status st;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [2:0] i_req_type = '0;
    logic signed [63:0] i_operand_a = '0;
    logic signed [63:0] i_operand_b = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [63:0] o_result_value;
    logic [1:0] o_status_code;

    t_outcome pending_q[$];
    int errors = 0;
    int checked = 0;
    int cycles = 0;
    int sent = 0;
    int rx_idle = 0;
    bit quiet_tail = 0;
    bit hold_out = 0;
    bit stim_done = 0;
    int op_seen[8];

    checked_integer_alu dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic t_outcome alu_outcome(t_op op, logic signed [63:0] a,
                                             logic signed [63:0] b);
        t_outcome o;
        logic signed [65:0] wide;
        logic signed [127:0] prod;
        logic signed [63:0] m;
        logic [63:0] mag;
        logic [127:0] acc;
        o.res = '0;
        o.st = ST_OK;
        case (op)
            OP_ADD, OP_SUB: begin
                wide = (op == OP_ADD) ? 66'(a) + 66'(b) : 66'(a) - 66'(b);
                if (wide > 66'(SMAX)) o.st = ST_OVER;
                else if (wide < 66'(SMIN)) o.st = ST_UNDER;
                else o.res = wide[63:0];
            end
            OP_MUL: begin
                prod = 128'(a) * 128'(b);
                if (prod > 128'(SMAX)) o.st = ST_OVER;
                else if (prod < 128'(SMIN)) o.st = ST_UNDER;
                else o.res = prod[63:0];
            end
            OP_DIV: begin
                if (b == 0) o.st = ST_DIVZ;
                else if (a == SMIN && b == -1) o.st = ST_OVER;
                else o.res = a / b;
            end
            OP_MOD: begin
                if (b == 0) o.st = ST_DIVZ;
                else if (b == -1 || b == 1) o.res = '0;
                else begin
                    m = a % b;
                    if (m != 0 && ((m < 0) != (b < 0))) m = m + b;
                    o.res = m;
                end
            end
            OP_REV: begin
                mag = a[63] ? 64'(0) - a : a;
                acc = '0;
                while (mag != 0) begin
                    acc = acc * 10 + 128'(mag % 10);
                    mag = mag / 10;
                end
                if (acc > 128'(SMAX)) o.st = ST_OVER;
                else o.res = a[63] ? -$signed(acc[63:0]) : $signed(acc[63:0]);
            end
            default: ;
        endcase
        if (o.st != ST_OK) o.res = '0;
        return o;
    endfunction

    function automatic logic signed [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return SMAX - $urandom_range(0, 3);
            1: return SMIN + $urandom_range(0, 3);
            2: return $signed(64'($urandom_range(0, 20))) - 10;
            3: return $signed({$urandom, $urandom}) >>> $urandom_range(0, 62);
            4: return $signed(64'($urandom)) - 64'sh8000_0000;
            5: return $signed(64'h0000_0000_8000_0000) + $urandom_range(0, 7);
            default: return $signed({$urandom, $urandom});
        endcase
    endfunction

    // reversal is slow per digit: keep half of the operands short
    function automatic logic signed [63:0] rev_operand();
        logic signed [63:0] v;
        case ($urandom_range(0, 9))
            0: v = SMIN;
            1: v = SMAX;
            2: v = 64'sd9_000_000_000_000_000_009 / 10 * 10 + $urandom_range(0, 9);
            3: v = $signed({$urandom, $urandom});
            4: v = 64'($urandom_range(0, 9)) * 64'd1_000_000_000_000_000_000
                   + 64'($urandom_range(0, 99));
            default: v = 64'($urandom_range(0, 99999));
        endcase
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send(t_op op, logic signed [63:0] a, logic signed [63:0] b);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            idle_cycles($urandom_range(1, 9));
        end
        i_valid <= 1'b1;
        i_req_type <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_ready);
        pending_q.push_back(alu_outcome(op, a, b));
        op_seen[op]++;
        sent++;
    endtask

    task automatic run_directed();
        t_row rows[$];
        t_outcome got;
        rows = '{
            '{OP_ADD, SMAX, 64'sd1, 1'b1, 64'sd0, ST_OVER},
            '{OP_ADD, SMIN, -64'sd1, 1'b1, 64'sd0, ST_UNDER},
            '{OP_ADD, SMAX, SMIN, 1'b1, -64'sd1, ST_OK},
            '{OP_SUB, 64'sd0, SMIN, 1'b1, 64'sd0, ST_OVER},
            '{OP_SUB, SMIN, 64'sd1, 1'b1, 64'sd0, ST_UNDER},
            '{OP_SUB, -64'sd1, SMIN, 1'b1, SMAX, ST_OK},
            '{OP_MUL, SMIN, 64'sd0, 1'b1, 64'sd0, ST_OK},
            '{OP_MUL, SMIN, -64'sd1, 1'b1, 64'sd0, ST_OVER},
            '{OP_MUL, SMAX, 64'sd2, 1'b1, 64'sd0, ST_OVER},
            '{OP_MUL, SMAX, -64'sd2, 1'b1, 64'sd0, ST_UNDER},
            '{OP_MUL, SMIN, 64'sd1, 1'b1, SMIN, ST_OK},
            '{OP_DIV, SMAX, 64'sd0, 1'b1, 64'sd0, ST_DIVZ},
            '{OP_DIV, SMIN, -64'sd1, 1'b1, 64'sd0, ST_OVER},
            '{OP_DIV, -64'sd7, 64'sd2, 1'b1, -64'sd3, ST_OK},
            '{OP_MOD, 64'sd5, 64'sd0, 1'b1, 64'sd0, ST_DIVZ},
            '{OP_MOD, SMIN, -64'sd1, 1'b1, 64'sd0, ST_OK},
            '{OP_MOD, -64'sd7, 64'sd3, 1'b1, 64'sd2, ST_OK},
            '{OP_MOD, 64'sd7, -64'sd3, 1'b1, -64'sd2, ST_OK},
            '{OP_MOD, SMIN, SMAX, 1'b0, 64'sd0, ST_OK},
            '{OP_REV, 64'sd0, 64'sd0, 1'b1, 64'sd0, ST_OK},
            '{OP_REV, -64'sd1200, SMAX, 1'b1, -64'sd21, ST_OK},
            '{OP_REV, SMIN, 64'sd0, 1'b1, -64'sd8085774586302733229, ST_OK},
            '{OP_REV, SMAX, 64'sd0, 1'b1, 64'sd7085774586302733229, ST_OK},
            '{OP_REV, 64'sd1000000000000000099, 64'sd0, 1'b1, 64'sd0, ST_OVER},
            '{OP_NA6, SMAX, SMIN, 1'b1, 64'sd0, ST_OK},
            '{OP_NA7, -64'sd1, -64'sd1, 1'b1, 64'sd0, ST_OK}
        };
        foreach (rows[k]) begin
            if (rows[k].check) begin
                got = alu_outcome(rows[k].op, rows[k].a, rows[k].b);
                if (got.res !== rows[k].res || got.st !== rows[k].st) begin
                    $display("%0t: table row %0d: expected %0d/%0d, actual %0d/%0d",
                             $time, k, rows[k].res, rows[k].st, got.res, got.st);
                    errors++;
                end
            end
            send(rows[k].op, rows[k].a, rows[k].b);
        end
    endtask

    // stimulus
    initial begin
        t_op op;
        idle_cycles(12);
        i_rst_n <= 1'b1;
        idle_cycles(2);
        run_directed();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 150) quiet_tail = 1;
            if (n == 200) hold_out = 1;
            op = t_op'($urandom_range(0, 7));
            if (op == OP_REV) send(op, rev_operand(), pick_operand());
            else if (op == OP_DIV || op == OP_MOD)
                send(op, pick_operand(),
                     $urandom_range(0, 7) == 0 ? 64'sd0 : pick_operand());
            else send(op, pick_operand(), pick_operand());
        end
        i_valid <= 1'b0;
        stim_done = 1;
    end

    // long output stall while requests keep coming
    initial begin
        wait (hold_out);
        @(posedge i_clk);
        idle_cycles(3000);
        hold_out = 0;
    end

    // receiver: idles in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_out) begin
            i_ready <= 1'b0;
        end else if (rx_idle > 0) begin
            i_ready <= 1'b0;
            rx_idle--;
        end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            i_ready <= 1'b0;
            rx_idle = $urandom_range(0, 8);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_outcome exp_o;
        cycles++;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: transfer with no request pending: %0d/%0d",
                         $time, o_result_value, o_status_code);
                errors++;
            end else begin
                exp_o = pending_q.pop_front();
                checked++;
                if (o_result_value !== exp_o.res) begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, exp_o.res, o_result_value);
                    errors++;
                end
                if (o_status_code !== exp_o.st) begin
                    $display("%0t: status_code expected %0d actual %0d",
                             $time, exp_o.st, o_status_code);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done && pending_q.size() == 0);
        idle_cycles(100);
        $display("%0d requests sent, %0d results checked; ops add..na7: %0d %0d %0d %0d",
                 sent, checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("  %0d %0d %0d %0d; covered extremes, error statuses, idling, long stall",
                 op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
        if (errors == 0) begin
            $display("checked_integer_alu regression: pass");
        end else begin
            $display("checked_integer_alu regression: fail");
        end
        $finish;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
        $display("checked_integer_alu regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/cia_pkg.sv
rtl/cia_dpath.sv
rtl/checked_integer_alu.sv
test/checked_integer_alu_tb.sv
